/* sv/b2da_pkg.sv */
// types, constants and the shift-and-add-3 step shared by the
// binary to decimal ascii unit; no dependencies
package b2da_pkg;

    localparam int VALUE_W      = 32;
    localparam int MIN_W        = 4;
    localparam int CHAR_W       = 6;
    localparam int DIGIT_W      = 4;
    localparam int VALUE_DIGITS = 10;
    localparam int BCD_W        = VALUE_DIGITS * DIGIT_W;
    localparam int MIN_MAX      = (1 << MIN_W) - 1;

    // double-dabble split: STEP_BITS bits per stage, NUM_STAGES stages
    localparam int STEP_BITS    = 8;
    localparam int NUM_STAGES   = VALUE_W / STEP_BITS;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);

    // input transfer
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [MIN_W-1:0]   min_digits;
    } in_t;

    // result transfer, one per character
    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              is_last;
    } out_t;

    // word carried down the conversion pipeline
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
        logic [MIN_W-1:0]   min_digits;
    } dabble_t;

    // one shift-and-add-3 step: correct every digit, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble_shift(input logic [BCD_W-1:0] bcd,
                                                      input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < VALUE_DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

/* sv/b2da_dabble_stage.sv */
// one register stage of the binary to bcd pipeline, STEP_BITS shift steps
// depends on b2da_pkg
module b2da_dabble_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  b2da_pkg::dabble_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output b2da_pkg::dabble_t out_data
);
    import b2da_pkg::*;

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    // stage takes a transfer when empty or when its content moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // consume the next STEP_BITS bits, msb first
    always_comb begin
        data_next = in_data;
        for (int i = 0; i < STEP_BITS; i++) begin
            data_next.bcd = dabble_shift(data_next.bcd, data_next.bin[VALUE_W-1]);
            data_next.bin = {data_next.bin[VALUE_W-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    // a stalled stage keeps its word
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled dabble stage lost or changed its word");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted word did not occupy the dabble stage");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_ready && !in_valid |=> !valid_reg)
        else $error("dabble stage still full after its word moved on");

endmodule

/* sv/b2da_serializer.sv */
// sizes the digit run of a converted number and emits one ascii character
// per cycle while m_ready allows, via an output register; depends on b2da_pkg
module b2da_serializer #(
    parameter int MAX_DIGITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  b2da_pkg::dabble_t in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output b2da_pkg::out_t    m_data
);
    import b2da_pkg::*;

    localparam int RUN_CAP   = (VALUE_DIGITS > MIN_MAX) ? VALUE_DIGITS : MIN_MAX;
    localparam int TOTAL_MAX = (MAX_DIGITS < RUN_CAP) ? MAX_DIGITS : RUN_CAP;
    localparam int POS_W     = (TOTAL_MAX > 1) ? $clog2(TOTAL_MAX) : 1;
    localparam int CNT_LIM   = (MAX_DIGITS > RUN_CAP) ? MAX_DIGITS : RUN_CAP;
    localparam int CNT_W     = $clog2(CNT_LIM + 1);

    logic                                   active_reg;
    logic [POS_W-1:0]                       pos_reg;
    logic [VALUE_DIGITS-1:0][DIGIT_W-1:0]   digits_reg;
    logic                                   m_valid_reg;
    out_t                                   m_data_reg;

    logic             emit;
    logic             last_now;
    logic             load;
    logic [CNT_W-1:0] n_raw;
    logic [CNT_W-1:0] n_cap;
    logic [CNT_W-1:0] min_cap;
    logic [CNT_W-1:0] total;
    logic [3:0]       sel;
    logic [CHAR_W-1:0] char_val;

    // output register free or draining, and a run in progress
    assign emit     = active_reg && (!m_valid_reg || m_ready);
    assign last_now = (pos_reg == '0);
    assign in_ready = !active_reg || (emit && last_now);
    assign load     = in_valid && in_ready;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // run length: significant digits and minimum, both capped
    always_comb begin
        n_raw = '0;
        for (int d = 0; d < VALUE_DIGITS; d++) begin
            if (in_data.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
                n_raw = CNT_W'(d + 1);
            end
        end
        n_cap   = (n_raw > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : n_raw;
        min_cap = (CNT_W'(in_data.min_digits) > CNT_W'(MAX_DIGITS)) ?
                  CNT_W'(MAX_DIGITS) : CNT_W'(in_data.min_digits);
        total   = (n_cap > min_cap) ? n_cap : min_cap;
    end

    // character at the current position, padding beyond the stored digits
    always_comb begin
        sel      = 4'(pos_reg);
        char_val = CHAR_ZERO;
        if (CNT_W'(pos_reg) < CNT_W'(VALUE_DIGITS)) begin
            char_val = CHAR_ZERO + CHAR_W'(digits_reg[sel]);
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load) begin
                active_reg <= (total != '0);
            end else if (emit && last_now) begin
                active_reg <= 1'b0;
            end
        end
    end

    // payload, a load overrides the countdown
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.digit_char <= char_val;
            m_data_reg.is_last    <= last_now;
        end
        if (load) begin
            digits_reg <= in_data.bcd;
            pos_reg    <= POS_W'(total - CNT_W'(1));
        end else if (emit) begin
            pos_reg    <= pos_reg - POS_W'(1);
        end
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> CNT_W'(pos_reg) < CNT_W'(TOTAL_MAX))
        else $error("character position beyond the longest run");

    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.is_last |-> active_reg)
        else $error("non-final character with no run in progress");

    a_run_ends_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> m_valid_reg && m_data_reg.is_last)
        else $error("run ended without a final character");

endmodule

/* sv/binary_to_decimal_ascii_unit.sv */
// Converts a 32-bit unsigned value to decimal ASCII characters, most
// significant first, left-padded with '0' to min_digits (capped at
// MAX_DIGITS), one character per m_ transfer with is_last on the final one;
// a zero value with a zero minimum produces no characters. The value passes
// through four shift-and-add-3 register stages of eight bits each, then the
// serializer, which registers the digits and then each character in its
// output register. The serializer emits one character per cycle while
// m_ready allows, holding a number until its last character is out, and
// new values keep entering the pipeline meanwhile. Depends on b2da_pkg,
// b2da_dabble_stage and b2da_serializer.
module binary_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  b2da_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output b2da_pkg::out_t  m_data
);
    import b2da_pkg::*;

    logic [NUM_STAGES:0] stg_valid;
    logic [NUM_STAGES:0] stg_ready;
    dabble_t             stg_data [NUM_STAGES+1];

    // pipeline entry: empty bcd, value to be shifted out msb first
    always_comb begin
        stg_data[0].bcd        = '0;
        stg_data[0].bin        = s_data.value;
        stg_data[0].min_digits = s_data.min_digits;
    end
    assign stg_valid[0] = s_valid;
    assign s_ready      = stg_ready[0];

    // conversion stages
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        b2da_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // character output
    b2da_serializer #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[NUM_STAGES]),
        .in_ready (stg_ready[NUM_STAGES]),
        .in_data  (stg_data[NUM_STAGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* sim/tb_binary_to_decimal_ascii_unit.sv */
// testbench for binary_to_decimal_ascii_unit: random and directed numbers in,
// decimal characters checked against a local digit predictor; uses b2da_pkg
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_unit;

    import b2da_pkg::*;

    localparam int DIGIT_CAP    = 10;
    localparam int RANDOM_ITEMS = 330;
    localparam int CALM_FROM    = 280;
    localparam int DRAIN_CYCLES = 40;

    // expected character stream, filled at each accepted input transfer
    class char_board;
        out_t expected_chars[$];
        int   errors = 0;

        function void note_number(in_t item);
            logic [DIGIT_W-1:0] digits[VALUE_DIGITS];
            logic [VALUE_W-1:0] rest;
            int                 n;
            int                 floor_len;
            int                 total;
            int                 pad;
            out_t               ch;
            rest = item.value;
            n    = 0;
            // peel decimal digits, least significant first
            while (rest != 0 && n < VALUE_DIGITS) begin
                digits[n] = DIGIT_W'(rest % 10);
                rest      = rest / 10;
                n++;
            end
            if (n > DIGIT_CAP) n = DIGIT_CAP;
            floor_len = (int'(item.min_digits) > DIGIT_CAP) ? DIGIT_CAP :
                        int'(item.min_digits);
            total     = (n > floor_len) ? n : floor_len;
            pad       = total - n;
            // leading zeros first, then digits most significant first
            for (int k = 0; k < total; k++) begin
                if (k < pad) begin
                    ch.digit_char = CHAR_ZERO;
                end else begin
                    ch.digit_char = CHAR_ZERO + CHAR_W'(digits[n - 1 - (k - pad)]);
                end
                ch.is_last = (k + 1 == total);
                expected_chars.push_back(ch);
            end
        endfunction

        function void check_char(out_t got);
            out_t want;
            if (expected_chars.size() == 0) begin
                $error("unexpected character transfer: digit_char %0d is_last %0d",
                       got.digit_char, got.is_last);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (got.digit_char !== want.digit_char) begin
                $error("digit_char expected %0d actual %0d", want.digit_char, got.digit_char);
                errors++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last expected %0d actual %0d", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    bit   calm    = 1'b0;
    int   stall_left = 0;

    char_board board = new();

    binary_to_decimal_ascii_unit #(
        .MAX_DIGITS(DIGIT_CAP)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // input transfer monitor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_number(s_data);
        end
    end

    // result transfer check and receiver stall bursts
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_char(m_data);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else if (aresetn && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one number per call; valid stays up when the next call follows directly
    task automatic send_number(input logic [VALUE_W-1:0] v, input logic [MIN_W-1:0] m);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{value: v, min_digits: m};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stimulus and end of run
    initial begin : stimulus
        longint unsigned    lo;
        longint unsigned    hi;
        int                 width;
        int                 kind;
        logic [VALUE_W-1:0] v;
        logic [MIN_W-1:0]   m;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty run, padding, saturated minimum, digit count edges
        send_number(32'd0, 4'd0);
        send_number(32'd0, 4'd1);
        send_number(32'd0, 4'd10);
        send_number(32'd0, 4'd15);
        send_number(32'd1, 4'd0);
        send_number(32'd9, 4'd0);
        send_number(32'd10, 4'd0);
        send_number(32'd99, 4'd2);
        send_number(32'd100, 4'd1);
        send_number(32'd12345, 4'd5);
        send_number(32'd12345, 4'd8);
        send_number(32'd42, 4'd11);
        send_number(32'd7, 4'd12);
        send_number(32'd0, 4'd13);
        send_number(32'd999999999, 4'd0);
        send_number(32'd1000000000, 4'd0);
        send_number(32'hFFFF_FFFF, 4'd0);
        send_number(32'hFFFF_FFFF, 4'd15);
        send_number(32'h8000_0000, 4'd3);
        send_number(32'h7FFF_FFFF, 4'd10);
        send_number(32'd5, 4'd14);
        send_number(32'd0, 4'd0);

        // random: spread over digit counts, with powers of ten and all nines
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM) calm = 1'b1;
            width = $urandom_range(1, 10);
            lo    = 1;
            repeat (width - 1) lo = lo * 10;
            hi    = lo * 10 - 1;
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            kind  = $urandom_range(0, 9);
            if (kind == 0) begin
                v = '0;
            end else if (kind <= 2) begin
                v = $urandom;
            end else if (kind == 3) begin
                v = VALUE_W'(lo);
            end else if (kind == 4) begin
                v = VALUE_W'(hi);
            end else begin
                v = VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
            if ($urandom_range(0, 3) == 0) begin
                m = MIN_W'(width);
            end else begin
                m = MIN_W'($urandom_range(0, MIN_MAX));
            end
            send_number(v, m);
        end
        s_valid <= 1'b0;

        // drain, then leave time for any stray character
        while (board.expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0) begin
            $display("binary_to_decimal_ascii_unit test passed");
        end else begin
            $display("binary_to_decimal_ascii_unit test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #500_000;
        $display("binary_to_decimal_ascii_unit test failed");
        $finish;
    end

endmodule
